// ===== hw/rtl/mrpt_pkg.sv =====
package mrpt_pkg;

  localparam int NumW = 63;
  localparam int NumBases = 7;
  localparam int BaseIdxW = 3;
  localparam int BitIdxW = 6;

  typedef logic [NumW-1:0] num_t;

  // Fixed witness set, exact for every 64-bit value
  function automatic num_t base_value(input logic [BaseIdxW-1:0] idx);
    num_t v;
    v = '0;
    case (idx)
      3'd0: v = 63'd2;
      3'd1: v = 63'd325;
      3'd2: v = 63'd9375;
      3'd3: v = 63'd28178;
      3'd4: v = 63'd450775;
      3'd5: v = 63'd9780504;
      3'd6: v = 63'd1795265022;
      default: v = 63'd2;
    endcase
    return v;
  endfunction

  // Datapath operation codes
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LOAD   = 3'd1,  // latch n, form n-1
    OP_SHIFTU = 3'd2,  // strip one trailing zero from u
    OP_BASE   = 3'd3,  // x = base mod n, acc = 1, e = u
    OP_MULACC = 3'd4,  // start acc = acc*x mod n
    OP_SQX    = 3'd5,  // start x = x*x mod n
    OP_XACC   = 3'd6,  // x = acc (power result)
    OP_SHIFTE = 3'd7   // e >>= 1
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [BaseIdxW-1:0] base_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic n_small;    // n < 2
    logic n_two;
    logic n_even;
    logic u_even;
    logic e_zero;
    logic e_lsb;
    logic x_le1;      // also covers a base that is a multiple of n
    logic x_nm1;
    logic x_one;
  } dp_stat_t;

endpackage

// ===== hw/rtl/mrpt_mulmod.sv =====
// Shift-and-add modular multiplier: one bit of y per cycle, MSB first.
module mrpt_mulmod (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  mrpt_pkg::num_t a,
  input  mrpt_pkg::num_t b,
  input  mrpt_pkg::num_t m,
  output logic          busy,
  output logic          done,
  output mrpt_pkg::num_t r
);
  import mrpt_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [BitIdxW-1:0] cnt_r, cnt_nxt;
  num_t               x_r, x_nxt;
  num_t               y_r, y_nxt;
  num_t               m_r, m_nxt;
  num_t               acc_r, acc_nxt;
  logic [NumW:0]      dbl, dsub, add, asub;
  num_t               stage1;

  // One doubling and conditional add per cycle, both reduced once
  always_comb begin
    dbl    = {acc_r, 1'b0};
    dsub   = dbl - {1'b0, m_r};
    stage1 = (dbl >= {1'b0, m_r}) ? dsub[NumW-1:0] : dbl[NumW-1:0];
    add    = {1'b0, stage1} + {1'b0, x_r};
    asub   = add - {1'b0, m_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    m_nxt    = m_r;
    acc_nxt  = acc_r;
    if (go && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = a;
      y_nxt    = b;
      m_nxt    = m;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (y_r[NumW-1]) begin
        acc_nxt = (add >= {1'b0, m_r}) ? asub[NumW-1:0] : add[NumW-1:0];
      end else begin
        acc_nxt = stage1;
      end
      y_nxt   = {y_r[NumW-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == BitIdxW'(NumW-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    m_r   <= m_nxt;
    acc_r <= acc_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign r    = acc_r;

endmodule

// ===== hw/rtl/mrpt_datapath.sv =====
// Operand registers, base reduction and flags
module mrpt_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  mrpt_pkg::num_t    in_number,
  input  mrpt_pkg::dp_cmd_t cmd,
  output mrpt_pkg::dp_stat_t stat
);
  import mrpt_pkg::*;

  num_t n_r, n_nxt;
  num_t nm1_r, nm1_nxt;
  num_t u_r, u_nxt;
  num_t e_r, e_nxt;
  num_t x_r, x_nxt;
  num_t acc_r, acc_nxt;
  logic [1:0] dst_r, dst_nxt;  // 1: acc, 2: x
  num_t bv, bmod;
  logic mgo, mbusy, mdone;
  num_t ma, mb, mr;

  localparam logic [1:0] DstNone = 2'd0;
  localparam logic [1:0] DstAcc  = 2'd1;
  localparam logic [1:0] DstX    = 2'd2;

  // Bases are below 2^31; n at least 3 here, so base mod n via multiplier
  assign bv = base_value(cmd.base_idx);

  always_comb begin
    mgo = 1'b0;
    ma  = acc_r;
    mb  = x_r;
    case (cmd.op)
      OP_MULACC: begin mgo = 1'b1; ma = acc_r; mb = x_r; end
      OP_SQX:    begin mgo = 1'b1; ma = x_r;   mb = x_r; end
      OP_BASE:   begin mgo = 1'b1; ma = 63'd1; mb = bv;  end
      default: ;
    endcase
  end

  // 1*base mod n: the base is walked bit by bit, adding 1 < n each step
  mrpt_mulmod u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (mgo),
    .a    (ma),
    .b    (mb),
    .m    (n_r),
    .busy (mbusy),
    .done (mdone),
    .r    (mr)
  );
  assign bmod = mr;

  always_comb begin
    n_nxt   = n_r;
    nm1_nxt = nm1_r;
    u_nxt   = u_r;
    e_nxt   = e_r;
    x_nxt   = x_r;
    acc_nxt = acc_r;
    dst_nxt = dst_r;
    case (cmd.op)
      OP_LOAD: begin
        n_nxt   = in_number;
        nm1_nxt = in_number - 1'b1;
        u_nxt   = in_number - 1'b1;
      end
      OP_SHIFTU: u_nxt = {1'b0, u_r[NumW-1:1]};
      OP_BASE: begin
        acc_nxt = 63'd1;
        e_nxt   = u_r;
        dst_nxt = DstX;
      end
      OP_MULACC: dst_nxt = DstAcc;
      OP_SQX:    dst_nxt = DstX;
      OP_XACC:   x_nxt = acc_r;
      OP_SHIFTE: e_nxt = {1'b0, e_r[NumW-1:1]};
      default: ;
    endcase
    if (mdone) begin
      if (dst_r == DstAcc) acc_nxt = bmod;
      else if (dst_r == DstX) x_nxt = bmod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst_r <= DstNone;
    end else begin
      dst_r <= dst_nxt;
    end
    n_r   <= n_nxt;
    nm1_r <= nm1_nxt;
    u_r   <= u_nxt;
    e_r   <= e_nxt;
    x_r   <= x_nxt;
    acc_r <= acc_nxt;
  end

  always_comb begin
    stat.mul_busy  = mbusy || mgo || mdone;
    stat.n_small   = (n_r < 63'd2);
    stat.n_two     = (n_r == 63'd2);
    stat.n_even    = !n_r[0];
    stat.u_even    = !u_r[0];
    stat.e_zero    = (e_r == '0);
    stat.e_lsb     = e_r[0];
    stat.x_le1     = (x_r <= 63'd1);
    stat.x_nm1     = (x_r == nm1_r);
    stat.x_one     = (x_r == 63'd1);
  end

endmodule

// ===== hw/rtl/mrpt_ctrl.sv =====
// Sequencer for the strong probable-prime test
module mrpt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  mrpt_pkg::dp_stat_t stat,
  output mrpt_pkg::dp_cmd_t  cmd,
  output logic               busy,
  output logic               out_valid,
  output logic               out_is_prime
);
  import mrpt_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_STRIP  = 4'd2;
  localparam logic [3:0] S_BASE   = 4'd3;
  localparam logic [3:0] S_PWAIT  = 4'd4;
  localparam logic [3:0] S_PSTEP  = 4'd5;
  localparam logic [3:0] S_PMW    = 4'd6;
  localparam logic [3:0] S_PSQ    = 4'd7;
  localparam logic [3:0] S_PSQW   = 4'd8;
  localparam logic [3:0] S_TEST   = 4'd9;
  localparam logic [3:0] S_SQ     = 4'd10;
  localparam logic [3:0] S_SQW    = 4'd11;
  localparam logic [3:0] S_SQCHK  = 4'd12;
  localparam logic [3:0] S_NEXT   = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic [3:0]          st_r, st_nxt;
  logic [BaseIdxW-1:0] bi_r, bi_nxt;
  logic [BitIdxW-1:0]  t_r, t_nxt;
  logic [BitIdxW-1:0]  s_r, s_nxt;
  logic                res_r, res_nxt;
  logic                ov_r, ov_nxt;

  always_comb begin
    st_nxt       = st_r;
    bi_nxt       = bi_r;
    t_nxt        = t_r;
    s_nxt        = s_r;
    res_nxt      = res_r;
    ov_nxt       = 1'b0;
    cmd.op       = OP_NONE;
    cmd.base_idx = bi_r;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          st_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        t_nxt = '0;
        bi_nxt = '0;
        if (stat.n_two) begin
          res_nxt = 1'b1; st_nxt = S_DONE;
        end else if (stat.n_small || stat.n_even) begin
          res_nxt = 1'b0; st_nxt = S_DONE;
        end else begin
          st_nxt = S_STRIP;
        end
      end
      // n-1 = u * 2^t
      S_STRIP: begin
        if (stat.u_even) begin
          cmd.op = OP_SHIFTU;
          t_nxt  = t_r + 1'b1;
        end else begin
          st_nxt = S_BASE;
        end
      end
      S_BASE: begin
        cmd.op = OP_BASE;
        st_nxt = S_PWAIT;
      end
      S_PWAIT: if (!stat.mul_busy) st_nxt = S_PSTEP;
      // right-to-left square-and-multiply, acc holds the power
      S_PSTEP: begin
        if (stat.e_zero) begin
          cmd.op = OP_XACC;
          st_nxt = S_TEST;
        end else if (stat.e_lsb) begin
          cmd.op = OP_MULACC;
          st_nxt = S_PMW;
        end else begin
          st_nxt = S_PSQ;
        end
      end
      S_PMW: if (!stat.mul_busy) st_nxt = S_PSQ;
      S_PSQ: begin
        cmd.op = OP_SQX;
        st_nxt = S_PSQW;
      end
      S_PSQW: begin
        if (!stat.mul_busy) begin
          cmd.op = OP_SHIFTE;
          st_nxt = S_PSTEP;
        end
      end
      S_TEST: begin
        s_nxt = 6'd1;
        if (stat.x_le1 || stat.x_nm1) st_nxt = S_NEXT;
        else st_nxt = S_SQ;
      end
      S_SQ: begin
        if (s_r >= t_r) begin
          res_nxt = 1'b0; st_nxt = S_DONE;
        end else begin
          cmd.op = OP_SQX;
          st_nxt = S_SQW;
        end
      end
      S_SQW: if (!stat.mul_busy) st_nxt = S_SQCHK;
      S_SQCHK: begin
        s_nxt = s_r + 1'b1;
        if (stat.x_one) begin
          res_nxt = 1'b0; st_nxt = S_DONE;
        end else if (stat.x_nm1) begin
          st_nxt = S_NEXT;
        end else begin
          st_nxt = S_SQ;
        end
      end
      S_NEXT: begin
        if (bi_r == BaseIdxW'(NumBases-1)) begin
          res_nxt = 1'b1; st_nxt = S_DONE;
        end else begin
          bi_nxt = bi_r + 1'b1;
          st_nxt = S_BASE;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      ov_r  <= 1'b0;
      bi_r  <= '0;
      t_r   <= '0;
      s_r   <= '0;
      res_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      ov_r  <= ov_nxt;
      bi_r  <= bi_nxt;
      t_r   <= t_nxt;
      s_r   <= s_nxt;
      res_r <= res_nxt;
    end
  end

  assign busy         = (st_r != S_IDLE);
  assign out_valid    = ov_r;
  assign out_is_prime = res_r;

endmodule

// ===== hw/rtl/miller_rabin_prime_test.sv =====
// Deterministic Miller-Rabin test of a 63-bit number. Pulse start with
// in_number while busy is low; one result appears on out_is_prime for a
// single cycle with out_valid, and the receiver cannot stall it. Time per
// request is set by the shared shift-and-add modular multiplier, which
// forms every product for each of the seven bases in turn; large primes
// take longest, while small, even and composite inputs finish far sooner.
// busy stays high until the result is shown.
module miller_rabin_prime_test (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  mrpt_pkg::num_t in_number,
  output logic           out_valid,
  output logic           out_is_prime
);
  import mrpt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mrpt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_is_prime(out_is_prime)
  );

  mrpt_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_number(in_number),
    .cmd      (cmd),
    .stat     (stat)
  );

  // A result strobe only ends a busy period
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without request");

  // Result strobe lasts a single cycle
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result strobe");

  // Accepted request raises busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request not taken");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import mrpt_pkg::*;

  localparam int CycleLimit = 30_000_000;
  localparam int TailCycles = 200;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  num_t in_number;
  logic out_valid;
  logic out_is_prime;

  miller_rabin_prime_test u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_number    (in_number),
    .out_valid    (out_valid),
    .out_is_prime (out_is_prime)
  );

  // Pending requests; a zero-number entry with drain set means wait for all results
  typedef struct {
    num_t n;
    bit   drain;
  } req_t;

  req_t   req_q[$];
  bit     verdict_q[$];
  int     fail_cnt;
  bit     stim_done;
  longint cyc;

  // Witness set of the deterministic test
  longint unsigned witness[7] = '{64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775,
                                  64'd9780504, 64'd1795265022};

  // (x * y) mod m by shift-and-add; m < 2^63 so nothing overflows
  function automatic longint unsigned mulmod(longint unsigned x, longint unsigned y,
                                             longint unsigned m);
    longint unsigned r;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = r + r;
      if (r >= m) r -= m;
      if (y[b]) begin
        r = r + x;
        if (r >= m) r -= m;
      end
    end
    return r;
  endfunction

  function automatic longint unsigned powmod(longint unsigned b, longint unsigned e,
                                             longint unsigned m);
    longint unsigned acc;
    acc = 1 % m;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, b, m);
      b = mulmod(b, b, m);
      e >>= 1;
    end
    return acc;
  endfunction

  function automatic bit predict_prime(num_t num);
    longint unsigned n, nm1, u, x;
    int t;
    bit hit;
    n = {1'b0, num};
    if (n < 2) return 0;
    if (n == 2) return 1;
    if (!n[0]) return 0;
    nm1 = n - 1;
    u = nm1;
    t = 0;
    while (!u[0]) begin
      u >>= 1;
      t++;
    end
    for (int k = 0; k < 7; k++) begin
      x = powmod(witness[k] % n, u, n);
      if (x <= 1 || x == nm1) continue;
      hit = 0;
      for (int s = 1; s < t; s++) begin
        x = mulmod(x, x, n);
        if (x == 1) return 0;
        if (x == nm1) begin
          hit = 1;
          break;
        end
      end
      if (!hit) return 0;
    end
    return 1;
  endfunction

  function automatic num_t rand_num(int bits);
    num_t v;
    v = num_t'({$urandom, $urandom});
    if (bits < 63) v = v & ((num_t'(1) << bits) - 1);
    return v;
  endfunction

  task automatic push_num(num_t v);
    req_q.push_back('{v, 1'b0});
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Reset and stimulus
  initial begin
    num_t pr;
    stim_done = 1'b0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: small values, extremes, even, base multiples, known primes
    push_num(63'd0);
    push_num(63'd1);
    push_num(63'd2);
    push_num(63'd3);
    push_num(63'd4);
    push_num(63'd5);   // 325 and 9375 are multiples of 5
    push_num(63'd13);  // 325 = 25 * 13
    push_num(63'd97);
    push_num(63'd561);   // Carmichael number
    push_num(63'd2047);  // strong pseudoprime to base 2
    push_num(63'd1795265022);
    push_num(63'd3215031751);
    push_num(63'd1000000007);
    push_num(63'h7FFF_FFFF_FFFF_FFFF);
    push_num(63'h7FFF_FFFF_FFFF_FFE7);  // largest 63-bit prime
    push_num(63'h4000_0000_0000_0000);
    push_num(63'h5555_5555_5555_5555);
    push_num(63'h2AAA_AAAA_AAAA_AAAB);
    push_num(63'd4611686014132420609);  // (2^31-1)^2
    push_num(63'd65537);                // t = 16
    req_q.push_back('{'0, 1'b1});
    // Random: mostly odd, widths spread from 2 to 62 bits, a fifth at 63 bits
    for (int i = 0; i < 80; i++) begin
      pr = rand_num($urandom_range(4) == 0 ? 63 : $urandom_range(62, 2));
      if ($urandom_range(9) != 0) pr[0] = 1'b1;
      push_num(pr);
      if (i == 50) req_q.push_back('{'0, 1'b1});
    end
    stim_done = 1'b1;
  end

  // Driver
  int gap_cnt;
  bit holding;
  initial begin
    start = 1'b0;
    in_number = '0;
    gap_cnt = 0;
    holding = 1'b0;
    fail_cnt = 0;
    cyc = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (holding && !busy) begin
        // request taken at this edge
        holding = 1'b0;
        gap_cnt = $urandom_range(3) == 0 ? 0 : $urandom_range(14);
      end
      if (!holding) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          start <= 1'b0;
        end else if (req_q.size() > 0 && req_q[0].drain) begin
          start <= 1'b0;
          if (verdict_q.size() == 0) void'(req_q.pop_front());
        end else if (req_q.size() > 0) begin
          req_t r;
          r = req_q.pop_front();
          verdict_q.push_back(predict_prime(r.n));
          in_number <= r.n;
          start <= 1'b1;
          holding = 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    bit exp_v;
    if (rst_n && out_valid) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result is_prime=%0b", out_is_prime);
        fail_cnt++;
      end else begin
        exp_v = verdict_q.pop_front();
        if (out_is_prime !== exp_v) begin
          $error("is_prime mismatch: expected %0b actual %0b", exp_v, out_is_prime);
          fail_cnt++;
        end
      end
    end
  end

  // End of run and timeout
  always @(posedge clk) begin
    cyc++;
    if (cyc > CycleLimit) begin
      $display("miller_rabin_prime_test test failed");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (req_q.size() == 0 && !holding);
    @(posedge clk);
    wait (verdict_q.size() == 0);
    repeat (TailCycles) @(posedge clk);
    if (fail_cnt == 0 && verdict_q.size() == 0) begin
      $display("miller_rabin_prime_test test passed");
    end else begin
      $display("miller_rabin_prime_test test failed");
    end
    $finish;
  end

endmodule
